>>> rtl/wsc_pkg.sv
// Shared types, constants and lookup functions of the waypoint steering controller.
package wsc_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GOAL_X   = 3'd0,
        REG_GOAL_Y   = 3'd1,
        REG_LIN_GAIN = 3'd2,
        REG_ANG_GAIN = 3'd3,
        REG_DIST_TOL = 3'd4,
        REG_ANG_TOL  = 3'd5
    } cfg_reg_t;

    // Register reset values
    localparam logic signed [15:0] GOAL_X_RST   = 16'sd0;
    localparam logic signed [15:0] GOAL_Y_RST   = 16'sd0;
    localparam logic [15:0]        LIN_GAIN_RST = 16'd2048;
    localparam logic [15:0]        ANG_GAIN_RST = 16'd2048;
    localparam logic [14:0]        DIST_TOL_RST = 15'd102;
    localparam logic [14:0]        ANG_TOL_RST  = 15'd819;

    // Arithmetic constants
    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [23:0] HALF_PI_Q20 = 24'sd1647099;
    localparam logic signed [23:0] Z_ROUND     = 24'sd64;
    localparam logic signed [35:0] GAIN_ROUND  = 36'sd2048;
    localparam int                 ATAN_LEN    = 24;
    localparam int                 SQRT_STEPS  = 17;
    localparam logic [14:0]        LIN_MAX     = 15'h7FFF;
    localparam logic signed [15:0] ANG_MAX     = 16'sh7FFF;
    localparam logic signed [15:0] ANG_MIN     = -16'sh8000;

    // Beat payloads
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] heading;
    } in_t;

    typedef struct packed {
        logic [14:0]        linear_velocity;
        logic signed [15:0] angular_velocity;
        logic               goal_reached;
    } out_t;

    // Configuration bundle
    typedef struct packed {
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic [15:0]        linear_gain;
        logic [15:0]        angular_gain;
        logic [14:0]        distance_tolerance;
        logic [14:0]        angle_tolerance;
    } cfg_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ITER,
        ST_ERR,
        ST_SEL,
        ST_MUL,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic mac_x;
        logic mac_y;
        logic iter;
        logic err;
        logic sel;
        logic mul;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // CORDIC arctangent table, 2^-20 rad units
    function automatic logic [19:0] atan_q20(input logic [4:0] idx);
        logic [19:0] val;
        case (idx)
            5'd0:    val = 20'd823550;
            5'd1:    val = 20'd486170;
            5'd2:    val = 20'd256879;
            5'd3:    val = 20'd130396;
            5'd4:    val = 20'd65451;
            5'd5:    val = 20'd32757;
            5'd6:    val = 20'd16383;
            5'd7:    val = 20'd8192;
            5'd8:    val = 20'd4096;
            5'd9:    val = 20'd2048;
            5'd10:   val = 20'd1024;
            5'd11:   val = 20'd512;
            5'd12:   val = 20'd256;
            5'd13:   val = 20'd128;
            5'd14:   val = 20'd64;
            5'd15:   val = 20'd32;
            5'd16:   val = 20'd16;
            5'd17:   val = 20'd8;
            5'd18:   val = 20'd4;
            5'd19:   val = 20'd2;
            5'd20:   val = 20'd1;
            default: val = 20'd0;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/wsc_ctrl.sv
// Sequencer of the steering controller: walks one pose through the datapath.
module wsc_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  wsc_pkg::dp_status_t status,
    output wsc_pkg::ctrl_cmd_t  cmd,
    output logic [$clog2(((CORDIC_STEPS < wsc_pkg::ATAN_LEN) ? CORDIC_STEPS
                 : wsc_pkg::ATAN_LEN) > wsc_pkg::SQRT_STEPS ?
                 ((CORDIC_STEPS < wsc_pkg::ATAN_LEN) ? CORDIC_STEPS : wsc_pkg::ATAN_LEN)
                 : wsc_pkg::SQRT_STEPS)-1:0] iter_idx
);

    localparam int EFF_STEPS = (CORDIC_STEPS < wsc_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                                   : wsc_pkg::ATAN_LEN;
    localparam int N_ITER    = (EFF_STEPS > wsc_pkg::SQRT_STEPS) ? EFF_STEPS
                                                                 : wsc_pkg::SQRT_STEPS;
    localparam int CW        = $clog2(N_ITER);
    localparam logic [CW-1:0] LAST_ITER = CW'(N_ITER - 1);

    wsc_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    // State and iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            wsc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = wsc_pkg::ST_SQX;
                end
            end
            wsc_pkg::ST_SQX:
            begin
                cmd.mac_x  = 1'b1;
                state_next = wsc_pkg::ST_SQY;
            end
            wsc_pkg::ST_SQY:
            begin
                cmd.mac_y  = 1'b1;
                cnt_next   = '0;
                state_next = wsc_pkg::ST_ITER;
            end
            wsc_pkg::ST_ITER:
            begin
                cmd.iter = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ITER)
                begin
                    state_next = wsc_pkg::ST_ERR;
                end
            end
            wsc_pkg::ST_ERR:
            begin
                cmd.err    = 1'b1;
                state_next = wsc_pkg::ST_SEL;
            end
            wsc_pkg::ST_SEL:
            begin
                cmd.sel    = 1'b1;
                state_next = wsc_pkg::ST_MUL;
            end
            wsc_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = wsc_pkg::ST_DONE;
            end
            wsc_pkg::ST_DONE:
            begin
                // hold until the output register can take the beat
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = wsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wsc_pkg::ST_IDLE;
            end
        endcase
    end

    assign iter_idx = cnt_reg;

endmodule

>>> rtl/wsc_dp.sv
// Datapath: offsets, square root, CORDIC bearing, heading error, gain and output register.
module wsc_dp #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wsc_pkg::in_t        in_data,
    input  wsc_pkg::cfg_t       cfg,
    input  wsc_pkg::ctrl_cmd_t  cmd,
    input  logic [$clog2(((CORDIC_STEPS < wsc_pkg::ATAN_LEN) ? CORDIC_STEPS
                 : wsc_pkg::ATAN_LEN) > wsc_pkg::SQRT_STEPS ?
                 ((CORDIC_STEPS < wsc_pkg::ATAN_LEN) ? CORDIC_STEPS : wsc_pkg::ATAN_LEN)
                 : wsc_pkg::SQRT_STEPS)-1:0] iter_idx,
    output wsc_pkg::dp_status_t status,
    output logic                out_valid,
    input  logic                out_stall,
    output wsc_pkg::out_t       out_data
);

    localparam int EFF_STEPS = (CORDIC_STEPS < wsc_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                                   : wsc_pkg::ATAN_LEN;
    localparam int N_ITER    = (EFF_STEPS > wsc_pkg::SQRT_STEPS) ? EFF_STEPS
                                                                 : wsc_pkg::SQRT_STEPS;
    localparam int CW        = $clog2(N_ITER);

    // Operand registers
    logic signed [16:0] dx_reg, dy_reg;
    logic signed [15:0] head_reg;

    // Square root state
    logic [33:0] rad_reg, res_reg, bit_reg;

    // CORDIC state
    logic signed [33:0] x_reg, y_reg;
    logic signed [23:0] z_reg;

    // Decision state
    logic signed [17:0] err_reg;
    logic               far_reg, rotate_reg, latch_reg;
    logic signed [34:0] prod_reg;

    // Output register
    logic          out_valid_reg;
    wsc_pkg::out_t out_data_reg;

    // Squaring multiplier, shared by both axes
    logic signed [16:0] sq_op;
    logic signed [33:0] sq;
    assign sq_op = cmd.mac_y ? dy_reg : dx_reg;
    assign sq    = sq_op * sq_op;

    // Quarter turn pre-rotation into the right half plane
    logic signed [33:0] x0, y0, xi, yi;
    logic signed [23:0] zi;
    assign x0 = {{3{dx_reg[16]}}, dx_reg, 14'b0};
    assign y0 = {{3{dy_reg[16]}}, dy_reg, 14'b0};
    always_comb
    begin
        xi = x0;
        yi = y0;
        zi = '0;
        if (dx_reg < 0)
        begin
            if (dy_reg >= 0)
            begin
                xi = y0;
                yi = -x0;
                zi = wsc_pkg::HALF_PI_Q20;
            end
            else
            begin
                xi = -y0;
                yi = x0;
                zi = -wsc_pkg::HALF_PI_Q20;
            end
        end
    end

    // One CORDIC micro-rotation
    logic signed [33:0] xs, ys;
    logic signed [23:0] atan_s;
    assign xs     = x_reg >>> iter_idx;
    assign ys     = y_reg >>> iter_idx;
    assign atan_s = $signed({4'b0, wsc_pkg::atan_q20(5'(iter_idx))});

    // One square root digit
    logic [33:0] trial;
    assign trial = res_reg + bit_reg;

    // Bearing rounding and heading error wrap
    logic signed [23:0] z_rnd;
    logic signed [17:0] bearing, e0, e1, e2;
    assign z_rnd   = (z_reg + wsc_pkg::Z_ROUND) >>> 7;
    assign bearing = z_rnd[17:0];
    assign e0      = bearing - 18'(head_reg);
    assign e1      = (e0 > wsc_pkg::PI_Q13) ? e0 - wsc_pkg::TWO_PI_Q13 : e0;
    assign e2      = (e1 < -wsc_pkg::PI_Q13) ? e1 + wsc_pkg::TWO_PI_Q13 : e1;

    // Tolerance checks
    logic [16:0] dist_val;
    logic [17:0] aerr;
    assign dist_val = res_reg[16:0];
    assign aerr     = err_reg[17] ? 18'(-err_reg) : 18'(err_reg);

    // Gain multiplier operands
    logic signed [17:0] g_op;
    logic signed [16:0] g_gain;
    assign g_op   = rotate_reg ? err_reg : $signed({1'b0, dist_val});
    assign g_gain = $signed({1'b0, rotate_reg ? cfg.angular_gain : cfg.linear_gain});

    // Round, shift and saturate
    logic signed [35:0] scaled;
    logic [14:0]        lin_sat;
    logic signed [15:0] ang_sat;
    assign scaled = ($signed({prod_reg[34], prod_reg}) + wsc_pkg::GAIN_ROUND) >>> 12;
    always_comb
    begin
        if (scaled > 36'sd32767)
        begin
            lin_sat = wsc_pkg::LIN_MAX;
            ang_sat = wsc_pkg::ANG_MAX;
        end
        else if (scaled < -36'sd32768)
        begin
            lin_sat = '0;
            ang_sat = wsc_pkg::ANG_MIN;
        end
        else
        begin
            lin_sat = scaled[14:0];
            ang_sat = scaled[15:0];
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dx_reg   <= 17'(cfg.goal_x) - 17'(in_data.pos_x);
            dy_reg   <= 17'(cfg.goal_y) - 17'(in_data.pos_y);
            head_reg <= in_data.heading;
        end
        if (cmd.mac_x)
        begin
            rad_reg <= unsigned'(sq);
            x_reg   <= xi;
            y_reg   <= yi;
            z_reg   <= zi;
        end
        if (cmd.mac_y)
        begin
            rad_reg <= rad_reg + unsigned'(sq);
            res_reg <= '0;
            bit_reg <= 34'd1 << 32;
        end
        if (cmd.iter)
        begin
            if (iter_idx < CW'(wsc_pkg::SQRT_STEPS))
            begin
                if (rad_reg >= trial)
                begin
                    rad_reg <= rad_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            if (iter_idx < CW'(EFF_STEPS))
            begin
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_s;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_s;
                end
            end
        end
        if (cmd.err)
        begin
            err_reg <= e2;
        end
        if (cmd.sel)
        begin
            far_reg    <= {1'b0, dist_val} > {3'b0, cfg.distance_tolerance};
            rotate_reg <= aerr > {3'b0, cfg.angle_tolerance};
        end
        if (cmd.mul)
        begin
            prod_reg <= g_gain * g_op;
        end
    end

    // Arrival latch, cleared by reset only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg <= 1'b0;
        end
        else if (cmd.sel && !({1'b0, dist_val} > {3'b0, cfg.distance_tolerance}))
        begin
            latch_reg <= 1'b1;
        end
    end

    // Output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg.goal_reached     <= latch_reg;
            out_data_reg.linear_velocity  <= (!latch_reg && far_reg && !rotate_reg)
                                             ? lin_sat : '0;
            out_data_reg.angular_velocity <= (!latch_reg && far_reg && rotate_reg)
                                             ? ang_sat : '0;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

>>> rtl/waypoint_steering_controller.sv
// Top level of the waypoint steering controller: configuration registers and instances.
//
// Proportional go-to-goal steering. Each input beat is one pose; the block answers with
// one beat holding a forward speed, a turn rate and the goal-reached flag. One pose is in
// flight at a time: the next pose is taken only after the current result has entered the
// output register, and the sequencer waits while that register is held by out_stall. Each
// pose passes through an iteration loop in which the bit-serial square root (17 digits)
// and the CORDIC bearing unit step together, plus the squaring, error, select, gain and
// output steps around it. The result sits in an output register, so a new pose is taken
// while the previous result still waits downstream. Configuration is written through a
// plain write port (index 0 goal_x to 5 angle_tolerance; other indices are ignored) and
// must be written while the block is idle. The goal-reached flag is cleared only by reset.
module waypoint_steering_controller #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  wsc_pkg::in_t                      in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output wsc_pkg::out_t                     out_data,
    input  logic                              cfg_wr_en,
    input  logic [wsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int EFF_STEPS = (CORDIC_STEPS < wsc_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                                   : wsc_pkg::ATAN_LEN;
    localparam int N_ITER    = (EFF_STEPS > wsc_pkg::SQRT_STEPS) ? EFF_STEPS
                                                                 : wsc_pkg::SQRT_STEPS;
    localparam int CW        = $clog2(N_ITER);

    wsc_pkg::cfg_t       cfg_reg;
    wsc_pkg::ctrl_cmd_t  cmd;
    wsc_pkg::dp_status_t status;
    logic [CW-1:0]       iter_idx;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.goal_x             <= wsc_pkg::GOAL_X_RST;
            cfg_reg.goal_y             <= wsc_pkg::GOAL_Y_RST;
            cfg_reg.linear_gain        <= wsc_pkg::LIN_GAIN_RST;
            cfg_reg.angular_gain       <= wsc_pkg::ANG_GAIN_RST;
            cfg_reg.distance_tolerance <= wsc_pkg::DIST_TOL_RST;
            cfg_reg.angle_tolerance    <= wsc_pkg::ANG_TOL_RST;
        end
        else if (cfg_wr_en)
        begin
            case (wsc_pkg::cfg_reg_t'(cfg_index))
                wsc_pkg::REG_GOAL_X:   cfg_reg.goal_x             <= $signed(cfg_data);
                wsc_pkg::REG_GOAL_Y:   cfg_reg.goal_y             <= $signed(cfg_data);
                wsc_pkg::REG_LIN_GAIN: cfg_reg.linear_gain        <= cfg_data;
                wsc_pkg::REG_ANG_GAIN: cfg_reg.angular_gain       <= cfg_data;
                wsc_pkg::REG_DIST_TOL: cfg_reg.distance_tolerance <= cfg_data[14:0];
                wsc_pkg::REG_ANG_TOL:  cfg_reg.angle_tolerance    <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer
    wsc_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd),
        .iter_idx (iter_idx)
    );

    // Datapath
    wsc_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .iter_idx  (iter_idx),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
